// ----- rtl/bcs_pkg.sv -----
package bcs_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned WORK_W  = 28;
  localparam int unsigned T_W     = 17;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_APPEND   = 2'd1;
  localparam logic [1:0] CMD_GENERATE = 2'd2;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_GEN    = 1'b1
  } bcs_op_e;

  // queued transaction: for append cnt is the store index, for generate the point count
  typedef struct packed {
    bcs_op_e            op;
    logic [CNT_W-1:0]   cnt;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } bcs_cmd_t;

endpackage

// ----- rtl/bcs_ram.sv -----
module bcs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bcs_front.sv -----
module bcs_front import bcs_pkg::*; #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         command_i,
  input  logic [COORD_W-1:0] point_x_i,
  input  logic [COORD_W-1:0] point_y_i,
  output logic               cmd_valid_o,
  output bcs_cmd_t           cmd_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] count_q, count_d;
  bcs_cmd_t      fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    used_q, used_d;
  logic          accept, push;
  bcs_cmd_t      push_cmd;

  assign busy_o = (used_q == 2'd2);
  assign accept = start_i && !busy_o;

  always_comb begin
    count_d  = count_q;
    push     = 1'b0;
    push_cmd = '{op: OP_APPEND, cnt: CNT_W'(count_q), px: point_x_i, py: point_y_i};
    if (accept) begin
      unique case (command_i)
        CMD_CLEAR: count_d = '0;
        CMD_APPEND: begin
          if (count_q < CW'(MAX_POINTS)) begin
            push    = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        CMD_GENERATE: begin
          push        = (count_q != '0);
          push_cmd.op = OP_GEN;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    used_d = used_q;
    if (push && !cmd_pop_i) used_d = used_q + 2'd1;
    if (!push && cmd_pop_i) used_d = used_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      used_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      used_q  <= used_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_cmd;
  end

  assign cmd_valid_o = (used_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= 2'd2)
    else $error("queue overfilled");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o)
    else $error("pop from empty queue");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule

// ----- rtl/bcs_back.sv -----
module bcs_back import bcs_pkg::*; #(
  parameter int unsigned MAX_POINTS   = 32,
  parameter int unsigned SAMPLE_STEPS = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bcs_cmd_t           cmd_i,
  output logic               cmd_pop_o,
  output logic               sample_valid_o,
  output logic [COORD_W-1:0] sample_x_o,
  output logic [COORD_W-1:0] sample_y_o,
  output logic [5:0]         sample_index_o,
  output logic               last_sample_o
);

  localparam int unsigned IW   = $clog2(MAX_POINTS);
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned TINC = 65536 / SAMPLE_STEPS;
  localparam int unsigned RINC = 65536 % SAMPLE_STEPS;
  localparam int unsigned R0   = SAMPLE_STEPS / 2;
  localparam int unsigned PW   = WORK_W + 1 + T_W + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RDA  = 6'b000010,
    S_CAP  = 6'b000100,
    S_MUL  = 6'b001000,
    S_WR   = 6'b010000,
    S_FRD  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_phase_q, out_phase_d;

  logic [CW-1:0]     n_q, n_d, lvl_q, lvl_d;
  logic [IW-1:0]     i_q, i_d;
  logic [5:0]        k_q, k_d;
  logic [T_W-1:0]    t_q, t_d;
  logic [6:0]        r_q, r_d;
  logic [WORK_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [PW-1:0] px_q, py_q;

  logic              ctrl_we, work_we;
  logic [IW-1:0]     raddr;
  logic [2*COORD_W-1:0] ctrl_rdata;
  logic [2*WORK_W-1:0]  work_rdata, work_wdata;
  logic [WORK_W-1:0] rx, ry, resx, resy;
  logic              top;

  logic              vld_q;
  logic [COORD_W-1:0] sx_q, sy_q;
  logic [5:0]        si_q;
  logic              sl_q;

  bcs_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_ctrl_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_we),
    .waddr_i(IW'(cmd_i.cnt)),
    .wdata_i({cmd_i.py, cmd_i.px}),
    .raddr_i(raddr),
    .rdata_o(ctrl_rdata)
  );

  bcs_ram #(.WIDTH(2 * WORK_W), .DEPTH(MAX_POINTS)) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (work_we),
    .waddr_i(i_q),
    .wdata_i(work_wdata),
    .raddr_i(raddr),
    .rdata_o(work_rdata)
  );

  assign top = (lvl_q == n_q);
  assign rx  = top ? {ctrl_rdata[COORD_W-1:0], 16'h0000} : work_rdata[WORK_W-1:0];
  assign ry  = top ? {ctrl_rdata[2*COORD_W-1:COORD_W], 16'h0000}
                   : work_rdata[2*WORK_W-1:WORK_W];

  function automatic logic [WORK_W-1:0] lerp_fin(logic [WORK_W-1:0] a,
                                                 logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = (p + PW'(32768)) >>> 16;
    return a + s[WORK_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] round_px(logic [WORK_W-1:0] v);
    logic [WORK_W:0] s;
    s = {1'b0, v} + (WORK_W + 1)'(32768);
    return (s[WORK_W:16] > 13'd4095) ? 12'd4095 : s[27:16];
  endfunction

  assign resx       = lerp_fin(ax_q, px_q);
  assign resy       = lerp_fin(ay_q, py_q);
  assign work_wdata = {resy, resx};

  always_comb begin
    state_d     = state_q;
    out_phase_d = 1'b0;
    n_d   = n_q;
    lvl_d = lvl_q;
    i_d   = i_q;
    k_d   = k_q;
    t_d   = t_q;
    r_d   = r_q;
    cmd_pop_o = 1'b0;
    ctrl_we   = 1'b0;
    work_we   = 1'b0;
    raddr     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_APPEND) begin
            ctrl_we = 1'b1;
          end else begin
            n_d   = CW'(cmd_i.cnt);
            lvl_d = CW'(cmd_i.cnt);
            i_d   = '0;
            k_d   = '0;
            t_d   = '0;
            r_d   = 7'(R0);
            state_d = (CW'(cmd_i.cnt) == CW'(1)) ? S_FRD : S_RDA;
          end
        end
      end
      S_RDA: begin
        raddr   = '0;
        state_d = S_CAP;
      end
      S_CAP: begin
        raddr   = IW'(1);
        state_d = S_MUL;
      end
      S_MUL: state_d = S_WR;
      S_WR: begin
        work_we = 1'b1;
        raddr   = i_q + IW'(2);
        if (CW'(i_q) + CW'(1) == lvl_q - CW'(1)) begin
          lvl_d   = lvl_q - CW'(1);
          i_d     = '0;
          state_d = (lvl_q - CW'(1) == CW'(1)) ? S_FRD : S_RDA;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = S_MUL;
        end
      end
      S_FRD: begin
        raddr = '0;
        if (out_phase_q) begin
          if (k_q == 6'(SAMPLE_STEPS)) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + 6'd1;
            if (r_q + 7'(RINC) >= 7'(SAMPLE_STEPS)) begin
              r_d = r_q + 7'(RINC) - 7'(SAMPLE_STEPS);
              t_d = t_q + T_W'(TINC) + T_W'(1);
            end else begin
              r_d = r_q + 7'(RINC);
              t_d = t_q + T_W'(TINC);
            end
            lvl_d   = n_q;
            i_d     = '0;
            state_d = (n_q == CW'(1)) ? S_FRD : S_RDA;
          end
        end else begin
          out_phase_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_phase_q <= 1'b0;
      vld_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_phase_q <= out_phase_d;
      vld_q       <= (state_q == S_FRD) && out_phase_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    lvl_q <= lvl_d;
    i_q   <= i_d;
    k_q   <= k_d;
    t_q   <= t_d;
    r_q   <= r_d;
    if (state_q == S_CAP) begin
      ax_q <= rx;
      ay_q <= ry;
    end
    if (state_q == S_MUL) begin
      bx_q <= rx;
      by_q <= ry;
      px_q <= PW'($signed({1'b0, rx}) - $signed({1'b0, ax_q})) * $signed({1'b0, t_q});
      py_q <= PW'($signed({1'b0, ry}) - $signed({1'b0, ay_q})) * $signed({1'b0, t_q});
    end
    if (state_q == S_WR) begin
      ax_q <= bx_q;
      ay_q <= by_q;
    end
    if ((state_q == S_FRD) && out_phase_q) begin
      sx_q <= round_px(rx);
      sy_q <= round_px(ry);
      si_q <= k_q;
      sl_q <= (k_q == 6'(SAMPLE_STEPS));
    end
  end

  assign sample_valid_o = vld_q;
  assign sample_x_o     = sx_q;
  assign sample_y_o     = sy_q;
  assign sample_index_o = si_q;
  assign last_sample_o  = sl_q && vld_q;

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> sample_index_o <= 6'(SAMPLE_STEPS))
    else $error("sample index out of range");
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_sample_o |-> sample_index_o == 6'(SAMPLE_STEPS))
    else $error("last flag on wrong sample");
  a_wr_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> $past(state_q == S_MUL))
    else $error("lerp write without product");
  a_gen_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.op == OP_GEN) |-> cmd_i.cnt != '0)
    else $error("generate with empty store");

endmodule

// ----- rtl/bezier_curve_sampler.sv -----
// Bezier curve sampler: start with command clear, append or generate is taken whenever busy_o
// is low, and busy_o only rises when the two-entry command queue is full. A generate on a
// non-empty store emits SAMPLE_STEPS+1 samples, one per sample_valid_o pulse; the receiver
// cannot stall, so each sample must be captured in its pulse cycle. Each sample is a de
// Casteljau pass: each level starts with the states S_RDA and S_CAP, then does its lerps on the
// working memory through S_MUL and S_WR, one lerp per pass through that pair. Appends are
// written to the control memory by the back end; clear only resets the count in the front end.
module bezier_curve_sampler import bcs_pkg::*; #(
  parameter int unsigned MAX_POINTS   = 32,
  parameter int unsigned SAMPLE_STEPS = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         command_i,
  input  logic [COORD_W-1:0] point_x_i,
  input  logic [COORD_W-1:0] point_y_i,
  output logic               sample_valid_o,
  output logic [COORD_W-1:0] sample_x_o,
  output logic [COORD_W-1:0] sample_y_o,
  output logic [5:0]         sample_index_o,
  output logic               last_sample_o
);

  logic     cmd_valid, cmd_pop;
  bcs_cmd_t cmd;

  bcs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .command_i  (command_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  bcs_back #(.MAX_POINTS(MAX_POINTS), .SAMPLE_STEPS(SAMPLE_STEPS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .sample_valid_o(sample_valid_o),
    .sample_x_o    (sample_x_o),
    .sample_y_o    (sample_y_o),
    .sample_index_o(sample_index_o),
    .last_sample_o (last_sample_o)
  );

endmodule

// ----- tb/sv/bezier_curve_sampler_tb.sv -----
module bezier_curve_sampler_tb;
  import bcs_pkg::*;

  localparam int unsigned NPTS  = 32;
  localparam int unsigned STEPS = 50;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [5:0]         idx;
    logic               last;
  } curve_sample_t;

  class curve_scoreboard;
    logic [COORD_W-1:0] store_x [NPTS];
    logic [COORD_W-1:0] store_y [NPTS];
    int unsigned        n_pts;
    curve_sample_t      pending_q [$];
    int unsigned        n_gen;
    int unsigned        n_full_gen;

    function new();
      n_pts = 0;
      n_gen = 0;
      n_full_gen = 0;
    endfunction

    function logic [COORD_W-1:0] eval_axis(bit use_y, longint unsigned t);
      longint unsigned w [NPTS];
      longint unsigned r;
      for (int i = 0; i < n_pts; i++) begin
        w[i] = longint'(use_y ? store_y[i] : store_x[i]) << 16;
      end
      for (int lvl = n_pts; lvl > 1; lvl--) begin
        for (int i = 0; i + 1 < lvl; i++) begin
          w[i] = (w[i] * (65536 - t) + w[i+1] * t + 32768) >> 16;
        end
      end
      r = (w[0] + 32768) >> 16;
      if (r > 4095) r = 4095;
      return r[COORD_W-1:0];
    endfunction

    function void note_command(logic [1:0] cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      curve_sample_t s;
      longint unsigned t;
      case (cmd)
        CMD_CLEAR: n_pts = 0;
        CMD_APPEND: begin
          if (n_pts < NPTS) begin
            store_x[n_pts] = x;
            store_y[n_pts] = y;
            n_pts++;
          end
        end
        CMD_GENERATE: begin
          if (n_pts != 0) begin
            n_gen++;
            if (n_pts == NPTS) n_full_gen++;
            for (int k = 0; k <= STEPS; k++) begin
              t = (longint'(k) * 65536 + STEPS / 2) / STEPS;
              if (t > 65536) t = 65536;
              s.x    = eval_axis(1'b0, t);
              s.y    = eval_axis(1'b1, t);
              s.idx  = k[5:0];
              s.last = (k == STEPS);
              pending_q.push_back(s);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function bit check_sample(curve_sample_t got, output string msg);
      curve_sample_t exp_s;
      if (pending_q.size() == 0) begin
        msg = $sformatf("unexpected sample x=%0d y=%0d k=%0d", got.x, got.y, got.idx);
        return 1'b0;
      end
      exp_s = pending_q.pop_front();
      if (got.x !== exp_s.x || got.y !== exp_s.y || got.idx !== exp_s.idx ||
          got.last !== exp_s.last) begin
        msg = $sformatf({"sample k=%0d: got x=%0d y=%0d k=%0d last=%0b, ",
                         "want x=%0d y=%0d k=%0d last=%0b"},
                        exp_s.idx, got.x, got.y, got.idx, got.last,
                        exp_s.x, exp_s.y, exp_s.idx, exp_s.last);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         command_i = CMD_CLEAR;
  logic [COORD_W-1:0] point_x_i = '0;
  logic [COORD_W-1:0] point_y_i = '0;
  logic               sample_valid_o;
  logic [COORD_W-1:0] sample_x_o;
  logic [COORD_W-1:0] sample_y_o;
  logic [5:0]         sample_index_o;
  logic               last_sample_o;

  curve_scoreboard sb = new();
  int unsigned n_err = 0;
  int unsigned n_items = 0;
  int unsigned n_samples = 0;
  bit          no_idle = 1'b0;

  bezier_curve_sampler #(.MAX_POINTS(NPTS), .SAMPLE_STEPS(STEPS)) i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .point_x_i, .point_y_i,
    .sample_valid_o, .sample_x_o, .sample_y_o, .sample_index_o, .last_sample_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    n_err++;
  endtask

  always @(posedge clk_i) begin
    curve_sample_t got;
    string msg;
    if (rst_ni && sample_valid_o) begin
      got.x = sample_x_o;
      got.y = sample_y_o;
      got.idx = sample_index_o;
      got.last = last_sample_o;
      n_samples++;
      if (!sb.check_sample(got, msg)) report(msg);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic idle_burst();
    int unsigned len;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 12);
      start_i <= 1'b0;
      repeat (len) @(negedge clk_i);
    end
  endtask

  task automatic send(logic [1:0] cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    idle_burst();
    start_i   <= 1'b1;
    command_i <= cmd;
    point_x_i <= x;
    point_y_i <= y;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(cmd, x, y);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    #200_000_000;
    $display("timeout waiting for samples");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned n;
    bit full_done;
    full_done = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed
    send(CMD_CLEAR, 12'd0, 12'd0);
    send(CMD_GENERATE, 12'd0, 12'd0);
    send(CMD_APPEND, 12'd4095, 12'd0);
    send(CMD_GENERATE, 12'd4095, 12'd4095);
    send(CMD_APPEND, 12'd0, 12'd4095);
    send(CMD_APPEND, 12'd4095, 12'd4095);
    send(CMD_GENERATE, 12'd0, 12'd0);
    send(CMD_UNUSED, 12'd4095, 12'd4095);
    send(CMD_GENERATE, 12'd0, 12'd0);
    drain();
    send(CMD_CLEAR, 12'd4095, 12'd4095);
    send(CMD_GENERATE, 12'd0, 12'd0);
    send(CMD_APPEND, 12'd0, 12'd0);
    send(CMD_APPEND, 12'd4095, 12'd4095);
    send(CMD_APPEND, 12'd0, 12'd0);
    send(CMD_GENERATE, 12'd2730, 12'd1365);

    // random sequences: clear, one to five appends (once NPTS+2 to overfill the store), generate
    while (n_items < 110) begin
      if (n_items > 90) no_idle = 1'b1;
      if ($urandom_range(0, 9) == 0)
        send(CMD_UNUSED, COORD_W'($urandom), COORD_W'($urandom));
      send(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
      if (!full_done && n_items > 40) begin
        n = NPTS + 2;
        full_done = 1'b1;
      end else begin
        n = $urandom_range(1, 5);
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0)
          send(CMD_APPEND, $urandom_range(0, 1) ? 12'd4095 : 12'd0,
               $urandom_range(0, 1) ? 12'd4095 : 12'd0);
        else
          send(CMD_APPEND, COORD_W'($urandom), COORD_W'($urandom));
      end
      if ($urandom_range(0, 11) == 0) drain();
      send(CMD_GENERATE, COORD_W'($urandom), COORD_W'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        send(CMD_APPEND, COORD_W'($urandom), COORD_W'($urandom));
        send(CMD_GENERATE, COORD_W'($urandom), COORD_W'($urandom));
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    $display("covered %0d transactions, %0d curves (%0d with a full store), %0d samples",
             n_items, sb.n_gen, sb.n_full_gen, n_samples);
    $display("including empty-store generates, unused commands and dropped appends");
    if (n_err == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
